// File: rtl/ptic_pkg.sv
// ----------------------------------------------------------------------------
// ptic_pkg
// shared types and constants for the periodic tetrahedron inversion check
// ----------------------------------------------------------------------------
package ptic_pkg;

  localparam int FIELD_BITS = 16;
  localparam int BOX_BITS   = 17;
  localparam int DIFF_BITS  = 17;
  localparam int VOL_BITS   = 52;
  localparam int LEN_BITS   = 34;
  localparam int NUM_EDGES  = 6;
  localparam int EDGE_IDX_BITS = 3;

  // edge order: (0,1) (0,2) (0,3) (1,2) (1,3) (2,3)
  localparam logic [1:0] EDGE_FIRST  [NUM_EDGES] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] EDGE_SECOND [NUM_EDGES] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

  typedef logic [FIELD_BITS-1:0]       coord_t;
  typedef logic [BOX_BITS-1:0]         box_t;
  typedef logic signed [DIFF_BITS-1:0] diff_t;
  typedef logic [EDGE_IDX_BITS-1:0]    edge_idx_t;

  typedef struct packed {
    coord_t v0_x;
    coord_t v0_y;
    coord_t v0_z;
    coord_t v1_x;
    coord_t v1_y;
    coord_t v1_z;
    coord_t v2_x;
    coord_t v2_y;
    coord_t v2_z;
    coord_t v3_x;
    coord_t v3_y;
    coord_t v3_z;
  } in_item_t;

  typedef struct packed {
    logic signed [VOL_BITS-1:0] signed_volume;
    logic                       inverted;
    logic [1:0]                 edge_first;
    logic [1:0]                 edge_second;
    logic [LEN_BITS-1:0]        edge_length_sq;
  } result_t;

  typedef struct packed {
    diff_t x;
    diff_t y;
    diff_t z;
  } vec_t;

  // wrapped edge vectors of all six pairs, handed from front to back
  typedef struct packed {
    vec_t [NUM_EDGES-1:0] edges;
  } edge_set_t;

  // back pipeline occupancy, used for output credit
  typedef struct packed {
    logic [2:0] inflight;
  } back_stat_t;

endpackage

// File: rtl/ptic_fifo.sv
// ----------------------------------------------------------------------------
// ptic_fifo
// small first-word-fall-through queue in flip-flops, power-of-two depth
// ----------------------------------------------------------------------------
module ptic_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  T                         wdata,
  output logic                     full,
  input  logic                     pop,
  output T                         rdata,
  output logic                     empty,
  output logic [$clog2(DEPTH):0]   count
);

  localparam int AW = $clog2(DEPTH);

  T               mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    level;
  logic           do_push;
  logic           do_pop;

  assign full    = (level == (AW+1)'(DEPTH));
  assign empty   = (level == '0);
  assign count   = level;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

endmodule

// File: rtl/ptic_front.sv
// ----------------------------------------------------------------------------
// ptic_front
// accepts vertex items and wraps the six pair differences into the box
// ----------------------------------------------------------------------------
module ptic_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ptic_pkg::in_item_t  item,
  output logic                full,
  input  ptic_pkg::box_t      box_size,
  output logic                q_push,
  output ptic_pkg::edge_set_t q_data,
  input  logic                q_full
);

  localparam ptic_pkg::coord_t COORD_MASK =
    ptic_pkg::coord_t'((32'd1 << COORD_BITS) - 32'd1);

  ptic_pkg::coord_t    vc [4][3];
  ptic_pkg::edge_set_t wrapped;
  ptic_pkg::edge_set_t r_data;
  logic                r_valid;
  logic                accept;

  // d = to - from, wrapped once: 2d >= L takes off L, 2d < -L adds L
  function automatic ptic_pkg::diff_t wrap(ptic_pkg::coord_t from, ptic_pkg::coord_t to,
                                           ptic_pkg::box_t len);
    logic signed [17:0] d;
    logic signed [18:0] d2;
    logic signed [18:0] l;
    logic signed [18:0] r;
    d  = $signed({2'b00, to}) - $signed({2'b00, from});
    d2 = {d, 1'b0};
    l  = $signed({2'b00, len});
    if (d2 >= l) begin
      r = 19'(d) - l;
    end else if (d2 < -l) begin
      r = 19'(d) + l;
    end else begin
      r = 19'(d);
    end
    return ptic_pkg::diff_t'(r[ptic_pkg::DIFF_BITS-1:0]);
  endfunction

  always_comb begin
    vc[0][0] = item.v0_x & COORD_MASK;
    vc[0][1] = item.v0_y & COORD_MASK;
    vc[0][2] = item.v0_z & COORD_MASK;
    vc[1][0] = item.v1_x & COORD_MASK;
    vc[1][1] = item.v1_y & COORD_MASK;
    vc[1][2] = item.v1_z & COORD_MASK;
    vc[2][0] = item.v2_x & COORD_MASK;
    vc[2][1] = item.v2_y & COORD_MASK;
    vc[2][2] = item.v2_z & COORD_MASK;
    vc[3][0] = item.v3_x & COORD_MASK;
    vc[3][1] = item.v3_y & COORD_MASK;
    vc[3][2] = item.v3_z & COORD_MASK;
  end

  always_comb begin
    for (int k = 0; k < ptic_pkg::NUM_EDGES; k++) begin
      wrapped.edges[k].x = wrap(vc[ptic_pkg::EDGE_FIRST[k]][0],
                                vc[ptic_pkg::EDGE_SECOND[k]][0], box_size);
      wrapped.edges[k].y = wrap(vc[ptic_pkg::EDGE_FIRST[k]][1],
                                vc[ptic_pkg::EDGE_SECOND[k]][1], box_size);
      wrapped.edges[k].z = wrap(vc[ptic_pkg::EDGE_FIRST[k]][2],
                                vc[ptic_pkg::EDGE_SECOND[k]][2], box_size);
    end
  end

  assign full   = r_valid && q_full;
  assign accept = push && !full;
  assign q_push = r_valid && !q_full;
  assign q_data = r_data;

  always_ff @(posedge clk) begin
    if (accept) begin
      r_data <= wrapped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (accept) begin
      r_valid <= 1'b1;
    end else if (q_push) begin
      r_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/ptic_back.sv
// ----------------------------------------------------------------------------
// ptic_back
// four-stage pipeline: triple product and shortest edge search
// ----------------------------------------------------------------------------
module ptic_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 issue,
  input  ptic_pkg::edge_set_t  q_data,
  output logic                 res_valid,
  output ptic_pkg::result_t    res,
  output ptic_pkg::back_stat_t stat
);

  localparam int NE = ptic_pkg::NUM_EDGES;

  function automatic logic [31:0] sq32(ptic_pkg::diff_t d);
    logic signed [33:0] p;
    p = 34'(d) * 34'(d);
    return p[31:0];
  endfunction

  logic [3:0] v;

  // stage 1
  logic signed [33:0]  p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
  ptic_pkg::vec_t      e2_s1;
  logic [31:0]         sq [NE][3];

  // stage 2
  logic signed [34:0]           cx, cy, cz;
  ptic_pkg::vec_t               e2_s2;
  logic [ptic_pkg::LEN_BITS-1:0] len [NE];

  // stage 3
  logic signed [ptic_pkg::VOL_BITS-1:0] m_x, m_y, m_z;
  logic [ptic_pkg::LEN_BITS-1:0] len_a, len_b;
  ptic_pkg::edge_idx_t           idx_a, idx_b;
  logic [ptic_pkg::LEN_BITS-1:0] len_a_next, len_b_next;
  ptic_pkg::edge_idx_t           idx_a_next, idx_b_next;

  // stage 4
  logic signed [ptic_pkg::VOL_BITS+1:0] vol_sum;
  ptic_pkg::result_t                    res_next;
  ptic_pkg::edge_idx_t                  win_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[2:0], issue};
    end
  end

  always_ff @(posedge clk) begin
    p_yz  <= 34'(q_data.edges[0].y) * 34'(q_data.edges[1].z);
    p_zy  <= 34'(q_data.edges[0].z) * 34'(q_data.edges[1].y);
    p_zx  <= 34'(q_data.edges[0].z) * 34'(q_data.edges[1].x);
    p_xz  <= 34'(q_data.edges[0].x) * 34'(q_data.edges[1].z);
    p_xy  <= 34'(q_data.edges[0].x) * 34'(q_data.edges[1].y);
    p_yx  <= 34'(q_data.edges[0].y) * 34'(q_data.edges[1].x);
    e2_s1 <= q_data.edges[2];
    for (int k = 0; k < NE; k++) begin
      sq[k][0] <= sq32(q_data.edges[k].x);
      sq[k][1] <= sq32(q_data.edges[k].y);
      sq[k][2] <= sq32(q_data.edges[k].z);
    end
  end

  always_ff @(posedge clk) begin
    cx    <= 35'(p_yz) - 35'(p_zy);
    cy    <= 35'(p_zx) - 35'(p_xz);
    cz    <= 35'(p_xy) - 35'(p_yx);
    e2_s2 <= e2_s1;
    for (int k = 0; k < NE; k++) begin
      len[k] <= {2'b00, sq[k][0]} + {2'b00, sq[k][1]} + {2'b00, sq[k][2]};
    end
  end

  // first strict minimum within each half of the edge order
  always_comb begin
    len_a_next = len[0];
    idx_a_next = ptic_pkg::edge_idx_t'(0);
    for (int k = 1; k < 3; k++) begin
      if (len[k] < len_a_next) begin
        len_a_next = len[k];
        idx_a_next = ptic_pkg::edge_idx_t'(k);
      end
    end
    len_b_next = len[3];
    idx_b_next = ptic_pkg::edge_idx_t'(3);
    for (int k = 4; k < NE; k++) begin
      if (len[k] < len_b_next) begin
        len_b_next = len[k];
        idx_b_next = ptic_pkg::edge_idx_t'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    m_x   <= 52'(cx) * 52'(e2_s2.x);
    m_y   <= 52'(cy) * 52'(e2_s2.y);
    m_z   <= 52'(cz) * 52'(e2_s2.z);
    len_a <= len_a_next;
    len_b <= len_b_next;
    idx_a <= idx_a_next;
    idx_b <= idx_b_next;
  end

  always_comb begin
    vol_sum = 54'(m_x) + 54'(m_y) + 54'(m_z);
    win_idx = (len_b < len_a) ? idx_b : idx_a;
    res_next.signed_volume  = vol_sum[ptic_pkg::VOL_BITS-1:0];
    res_next.inverted       = vol_sum[ptic_pkg::VOL_BITS+1];
    res_next.edge_first     = ptic_pkg::EDGE_FIRST[win_idx];
    res_next.edge_second    = ptic_pkg::EDGE_SECOND[win_idx];
    res_next.edge_length_sq = (len_b < len_a) ? len_b : len_a;
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  assign res_valid     = v[3];
  assign stat.inflight = 3'($countones(v));

endmodule

// File: rtl/periodic_tetrahedron_inversion_check.sv
// ----------------------------------------------------------------------------
// periodic_tetrahedron_inversion_check
// orientation test and shortest wrapped edge of tetrahedra in a periodic box
// ----------------------------------------------------------------------------
// usage
// - input channel: drive item and raise push; a transfer happens on a rising
//   edge with push high and full low
// - result channel: while empty is low the oldest result sits on result;
//   raising pop transfers it
// - cfg_we/cfg_wdata write box_size; write only while no item is in flight
// - path: a result passes the front wrap register, the mid queue and the
//   four-stage multiply pipeline before it enters the output queue
// - throughput: one tetrahedron per cycle while the receiver keeps up, set by
//   the fully pipelined back part; each multiplier is used once per item
// - reset clears all queues and pipeline valids, box_size returns to
//   2^COORD_BITS
// - when the receiver stalls, results pile up in the output queue; the back
//   part issues only against free output slots, then the mid queue and the
//   front register fill and full rises; nothing is dropped
// ----------------------------------------------------------------------------
module periodic_tetrahedron_inversion_check #(
  parameter int COORD_BITS = 16,
  parameter int MID_DEPTH  = 2,
  parameter int OUT_DEPTH  = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ptic_pkg::in_item_t item,
  output logic               full,
  input  logic               pop,
  output ptic_pkg::result_t  result,
  output logic               empty,
  input  logic               cfg_we,
  input  logic [16:0]        cfg_wdata
);

  localparam int OAW = $clog2(OUT_DEPTH);
  localparam int CW  = OAW + 2;
  localparam ptic_pkg::box_t BOX_MASK  =
    ptic_pkg::box_t'((32'd1 << (COORD_BITS + 1)) - 32'd1);
  localparam ptic_pkg::box_t BOX_RESET =
    ptic_pkg::box_t'(32'd1 << COORD_BITS);

  ptic_pkg::box_t       box_size;
  logic                 q_push;
  ptic_pkg::edge_set_t  q_wdata;
  logic                 q_full;
  ptic_pkg::edge_set_t  q_rdata;
  logic                 q_empty;
  logic                 issue;
  logic                 res_valid;
  ptic_pkg::result_t    res;
  ptic_pkg::back_stat_t stat;
  logic                 out_full;
  logic [OAW:0]         out_count;
  logic [CW-1:0]        committed;

  // box length register
  always_ff @(posedge clk) begin
    if (rst) begin
      box_size <= BOX_RESET;
    end else if (cfg_we) begin
      box_size <= cfg_wdata & BOX_MASK;
    end
  end

  // front: accept and wrap
  ptic_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .box_size (box_size),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_full   (q_full)
  );

  // decoupling queue between front and back
  ptic_fifo #(
    .T     (ptic_pkg::edge_set_t),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (issue),
    .rdata (q_rdata),
    .empty (q_empty),
    .count ()
  );

  // issue only when every in-flight item has a reserved output slot
  assign committed = CW'(out_count) + CW'(stat.inflight);
  assign issue     = !q_empty && (committed < CW'(OUT_DEPTH));

  ptic_back u_back (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .q_data    (q_rdata),
    .res_valid (res_valid),
    .res       (res),
    .stat      (stat)
  );

  // result queue; never overflows thanks to the issue credit
  ptic_fifo #(
    .T     (ptic_pkg::result_t),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_valid && !out_full),
    .wdata (res),
    .full  (out_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty),
    .count (out_count)
  );

endmodule

// File: dv/periodic_tetrahedron_inversion_check_tb.sv
// ----------------------------------------------------------------------------
// periodic_tetrahedron_inversion_check_tb
// self-checking bench: directed tetrahedra, then random ones over a box sweep
// zero and oversized boxes included, every result checked against a table
// value or a prediction of the wrapped triple product and the shortest wrapped edge
// random idling on both sides, long receiver holds to back the block up
// ----------------------------------------------------------------------------
module periodic_tetrahedron_inversion_check_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no transfer on either side before the run is called hung
  localparam int QUIET_LIMIT = 2000;
  // margin after the last result comes back, so the pipe goes quiet
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_FIRST = 150;
  localparam int RANDOM_PER_BOX = 145;
  // box sweep: extremes (1, 0 = no wrap, 2^17-1 = above 2^16) and a few in between
  localparam int unsigned BOX_PLAN [9] = '{1, 0, 131071, 2, 1000, 65535, 32768,
                                            40000, 65536};
  localparam int unsigned BOX_RESET = 65536;

  typedef struct {
    ptic_pkg::in_item_t tet;
    bit                 typed;
    ptic_pkg::result_t  want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  ptic_pkg::in_item_t item = '0;
  logic               full;
  logic               pop = 1'b0;
  ptic_pkg::result_t  result;
  logic               empty;
  logic               cfg_we = 1'b0;
  logic [16:0]        cfg_wdata = '0;

  // bench copy of box_size, tracks every register write
  ptic_pkg::box_t     box_now = ptic_pkg::box_t'(BOX_RESET);
  // expected results in transfer order
  ptic_pkg::result_t  pending_orient [$];
  dir_row_t           dir_rows [$];
  int                 mismatches = 0;
  int                 results_seen = 0;
  // when set, neither side idles (forced receiver holds still apply)
  bit                 no_idle = 1'b0;

  periodic_tetrahedron_inversion_check dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .pop      (pop),
    .result   (result),
    .empty    (empty),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // one wrap of b - a toward [-L/2, L/2); a zero box leaves d alone
  function automatic longint wrap_delta(longint a, longint b, longint len);
    longint d;
    d = b - a;
    if (2 * d >= len) begin
      d -= len;
    end else if (2 * d < -len) begin
      d += len;
    end
    return d;
  endfunction

  // triple product of the wrapped edges from vertex 0, plus the shortest of
  // the six wrapped edges (earliest pair wins a tie)
  function automatic ptic_pkg::result_t tet_orientation(ptic_pkg::in_item_t t,
                                                        ptic_pkg::box_t bx);
    longint c [4][3];
    longint e [3][3];
    longint len, cx, cy, cz, vol, d, l2, best;
    int     bi, bj;
    ptic_pkg::result_t r;
    len = longint'(bx);
    c[0] = '{longint'(t.v0_x), longint'(t.v0_y), longint'(t.v0_z)};
    c[1] = '{longint'(t.v1_x), longint'(t.v1_y), longint'(t.v1_z)};
    c[2] = '{longint'(t.v2_x), longint'(t.v2_y), longint'(t.v2_z)};
    c[3] = '{longint'(t.v3_x), longint'(t.v3_y), longint'(t.v3_z)};
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        e[i][k] = wrap_delta(c[0][k], c[i+1][k], len);
      end
    end
    // a . (b x c)
    cx = e[0][1] * e[1][2] - e[0][2] * e[1][1];
    cy = e[0][2] * e[1][0] - e[0][0] * e[1][2];
    cz = e[0][0] * e[1][1] - e[0][1] * e[1][0];
    vol = cx * e[2][0] + cy * e[2][1] + cz * e[2][2];
    // pairs walked in (0,1),(0,2),(0,3),(1,2),(1,3),(2,3) order
    best = -1;
    bi = 0;
    bj = 1;
    for (int i = 0; i < 3; i++) begin
      for (int j = i + 1; j < 4; j++) begin
        l2 = 0;
        for (int k = 0; k < 3; k++) begin
          d = wrap_delta(c[i][k], c[j][k], len);
          l2 += d * d;
        end
        if (best < 0 || l2 < best) begin
          best = l2;
          bi = i;
          bj = j;
        end
      end
    end
    r.signed_volume  = vol[ptic_pkg::VOL_BITS-1:0];
    r.inverted       = (vol < 0);
    r.edge_first     = 2'(bi);
    r.edge_second    = 2'(bj);
    r.edge_length_sq = best[ptic_pkg::LEN_BITS-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic ptic_pkg::in_item_t tet(int ax, int ay, int az, int bx, int by, int bz,
                                             int cx, int cy, int cz, int dx, int dy, int dz);
    return {16'(ax), 16'(ay), 16'(az), 16'(bx), 16'(by), 16'(bz),
            16'(cx), 16'(cy), 16'(cz), 16'(dx), 16'(dy), 16'(dz)};
  endfunction

  // one row of the directed table
  task automatic add_row(ptic_pkg::in_item_t t, bit typed, ptic_pkg::result_t want);
    dir_row_t row;
    row.tet   = t;
    row.typed = typed;
    row.want  = want;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // idle length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // one coordinate of vertex 1..3, relative to the same axis of vertex 0
  function automatic ptic_pkg::coord_t pick_coord(int base, int len);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return ptic_pkg::coord_t'($urandom);
      4, 5: begin
        // inside the box when the box fits the coordinate range
        if (len >= 1 && len <= 65536) return ptic_pkg::coord_t'($urandom_range(0, len - 1));
        return ptic_pkg::coord_t'($urandom);
      end
      6, 7: begin
        // right on or next to the half-box wrap threshold
        case ($urandom_range(0, 3))
          0: return ptic_pkg::coord_t'(base + len / 2);
          1: return ptic_pkg::coord_t'(base + len / 2 - 1);
          2: return ptic_pkg::coord_t'(base - len / 2);
          default: return ptic_pkg::coord_t'(base - len / 2 - 1);
        endcase
      end
      // close to vertex 0: short edges, ties and flat tetrahedra
      default: return ptic_pkg::coord_t'(base + $urandom_range(0, 6) - 3);
    endcase
  endfunction

  function automatic ptic_pkg::in_item_t random_tet(ptic_pkg::box_t bx);
    ptic_pkg::coord_t c [12];
    for (int k = 0; k < 3; k++) begin
      c[k] = ptic_pkg::coord_t'($urandom);
    end
    for (int n = 3; n < 12; n++) begin
      c[n] = pick_coord(int'(c[n % 3]), int'(bx));
    end
    return {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], c[9], c[10], c[11]};
  endfunction

  // offer one tetrahedron and wait for its transfer; push stays high after
  // so a back-to-back item needs no second assignment in the same step
  task automatic send_tet(ptic_pkg::in_item_t t, bit typed, ptic_pkg::result_t want);
    int gap;
    gap = no_idle ? 0 : gap_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= t;
    do @(posedge clk); while (full !== 1'b0);
    pending_orient.insert(pending_orient.size(), typed ? want : tet_orientation(t, box_now));
  endtask

  // stop offering, let every result come back, then let the pipe go quiet
  task automatic settle();
    push <= 1'b0;
    while (pending_orient.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_box(int unsigned v);
    cfg_we <= 1'b1;
    cfg_wdata <= 17'(v);
    @(posedge clk);
    box_now = ptic_pkg::box_t'(v);
    cfg_we <= 1'b0;
  endtask

  task automatic report(string field, logic signed [63:0] want, logic signed [63:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // sender: directed table, then random tetrahedra over the box sweep
  // ---------------------------------------------------------------------------
  initial begin
    // degenerate: all vertices at the origin, then all at the top corner
    add_row(tet(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
            ptic_pkg::result_t'{52'sd0, 1'b0, 2'd0, 2'd1, 34'd0});
    add_row(tet(65535, 65535, 65535, 65535, 65535, 65535,
                65535, 65535, 65535, 65535, 65535, 65535), 1'b1,
            ptic_pkg::result_t'{52'sd0, 1'b0, 2'd0, 2'd1, 34'd0});
    // unit tetrahedron, right-handed
    add_row(tet(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1), 1'b1,
            ptic_pkg::result_t'{52'sd1, 1'b0, 2'd0, 2'd1, 34'd1});
    // same with vertices 1 and 2 swapped: inverted
    add_row(tet(0, 0, 0, 0, 1, 0, 1, 0, 0, 0, 0, 1), 1'b1,
            ptic_pkg::result_t'{-52'sd1, 1'b1, 2'd0, 2'd1, 34'd1});
    // vertex 1 one step behind the origin across the box seam
    add_row(tet(0, 0, 0, 65535, 0, 0, 0, 1, 0, 0, 0, 1), 1'b1,
            ptic_pkg::result_t'{-52'sd1, 1'b1, 2'd0, 2'd1, 34'd1});
    // differences of exactly +L/2 wrap to -L/2, exactly -L/2 stay
    add_row(tet(0, 0, 0, 32768, 0, 0, 0, 32768, 0, 0, 0, 32768), 1'b0, '0);
    add_row(tet(32768, 32768, 32768, 0, 32768, 32768,
                32768, 0, 32768, 32768, 32768, 0), 1'b0, '0);
    // one step inside the threshold on each side
    add_row(tet(0, 0, 0, 32767, 0, 0, 0, 32767, 0, 0, 0, 32767), 1'b0, '0);
    add_row(tet(32767, 32767, 32767, 0, 32767, 32767,
                32767, 0, 32767, 32767, 32767, 0), 1'b0, '0);
    // large volume near the top of the range
    add_row(tet(0, 0, 0, 32768, 32768, 0, 0, 32768, 32768,
                32768, 0, 32768), 1'b0, '0);
    // shortest edge is the last pair
    add_row(tet(0, 0, 0, 100, 0, 0, 0, 100, 0, 0, 101, 0), 1'b0, '0);
    // tie between a later pair and an earlier pair: earlier one wins
    add_row(tet(0, 0, 0, 5, 0, 0, 0, 7, 0, 5, 7, 0), 1'b0, '0);
    // alternating bit patterns on every field, then a mix with all-zero, all-one and sign-bit values
    add_row(tet(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
                16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555),
            1'b0, '0);
    add_row(tet(16'h5555, 16'haaaa, 16'h5555, 16'h0000, 16'hffff, 16'h8000,
                16'h7fff, 16'h0001, 16'hfffe, 16'haaaa, 16'h5555, 16'h0000),
            1'b0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset box size first
    foreach (dir_rows[n]) begin
      send_tet(dir_rows[n].tet, dir_rows[n].typed, dir_rows[n].want);
    end
    repeat (RANDOM_FIRST) send_tet(random_tet(box_now), 1'b0, '0);

    // box sweep, register only touched with the pipe empty
    foreach (BOX_PLAN[p]) begin
      settle();
      write_box(BOX_PLAN[p]);
      no_idle = ($urandom_range(0, 2) == 0);
      repeat (RANDOM_PER_BOX) send_tet(random_tet(box_now), 1'b0, '0);
    end

    settle();
    if (mismatches == 0 && pending_orient.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: random pops, forced long holds to back the block up
  // ---------------------------------------------------------------------------
  initial begin
    int                stall;
    int                next_hold;
    ptic_pkg::result_t want;
    stall = 0;
    next_hold = 200;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (pending_orient.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with nothing expected, actual vol %0d",
                   $time, result.signed_volume);
        end else begin
          want = pending_orient[0];
          pending_orient.delete(0);
          if (result.signed_volume !== want.signed_volume)
            report("signed_volume", want.signed_volume, result.signed_volume);
          if (result.inverted !== want.inverted)
            report("inverted", want.inverted, result.inverted);
          if (result.edge_first !== want.edge_first)
            report("edge_first", want.edge_first, result.edge_first);
          if (result.edge_second !== want.edge_second)
            report("edge_second", want.edge_second, result.edge_second);
          if (result.edge_length_sq !== want.edge_length_sq)
            report("edge_length_sq", want.edge_length_sq, result.edge_length_sq);
        end
        results_seen++;
      end
      // long hold while the sender keeps offering: output queue, mid queue
      // and front register fill up and full must rise
      if (stall == 0 && results_seen >= next_hold) begin
        stall = 100;
        next_hold = (next_hold == 200) ? 900 : 32'h7fff_ffff;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        stall = gap_len();
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: no transfer on either side for too long means a hang
  // ---------------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: periodic_tetrahedron_inversion_check.f
rtl/ptic_pkg.sv
rtl/ptic_fifo.sv
rtl/ptic_front.sv
rtl/ptic_back.sv
rtl/periodic_tetrahedron_inversion_check.sv
dv/periodic_tetrahedron_inversion_check_tb.sv
